// ===== hw/rtl/bhq_pkg.sv =====
// Package for the binary max-heap queue: sizes, command and status codes,
// the heap entry type and the memory request bundle.
// Depends on nothing; imported by bhq_ctrl and the top level.
package bhq_pkg;

  localparam int DEPTH   = 64;
  localparam int PRIO_W  = 16;
  localparam int TAG_W   = 16;
  localparam int CNT_W   = 7;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CHILD_W = ADDR_W + 2;
  localparam int ENTRY_W = PRIO_W + TAG_W;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/bhq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bhq_ctrl.sv =====
// Heap sequencer: decodes commands, walks the sift-up and sift-down paths
// through the entry RAM and registers the result. Depends on bhq_pkg.
module bhq_ctrl import bhq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        cmd,
  input  logic [PRIO_W-1:0] prio,
  input  logic [TAG_W-1:0]  tag,
  input  logic [CNT_W-1:0]  limit,
  output logic              busy,
  output mem_req_t          mem_req,
  input  entry_t            rdata,
  output logic              res_valid,
  output logic [1:0]        res_status,
  output logic [PRIO_W-1:0] res_prio,
  output logic [TAG_W-1:0]  res_tag,
  output logic [CNT_W-1:0]  res_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_RD_ROOT, S_RD_LAST,
    S_DN_CHK, S_DN_LEFT, S_DN_RIGHT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0] cidx_r, cidx_nxt;
  entry_t            mov_r, mov_nxt;
  entry_t            child_r, child_nxt;
  logic              deq_r, deq_nxt;
  logic              valid_r, valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [TAG_W-1:0]  otag_r, otag_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic [ADDR_W-1:0]  parent;
  logic [CHILD_W-1:0] left_c, right_c, n_ext;
  logic [CNT_W-1:0]   occ_dec;
  entry_t             big;
  logic [ADDR_W-1:0]  big_idx;

  assign parent  = (i_r - ADDR_W'(1)) >> 1;
  assign left_c  = {1'b0, i_r, 1'b1};
  assign right_c = {1'b0, i_r, 1'b0} + CHILD_W'(2);
  assign n_ext   = CHILD_W'(n_r);
  assign occ_dec = occ_r - CNT_W'(1);
  // pick the right child only if strictly greater than the held left child
  assign big     = (rdata.prio > child_r.prio) ? rdata : child_r;
  assign big_idx = (rdata.prio > child_r.prio) ? right_c[ADDR_W-1:0] : cidx_r;

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    cidx_nxt   = cidx_r;
    mov_nxt    = mov_r;
    child_nxt  = child_r;
    deq_nxt    = deq_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    oprio_nxt  = oprio_r;
    otag_nxt   = otag_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = STAT_DONE;
          oprio_nxt  = '0;
          otag_nxt   = '0;
          priority if (cmd == CMD_ENQ) begin
            if (occ_r >= limit) begin
              status_nxt = STAT_FULL;
              valid_nxt  = 1'b1;
            end else begin
              mov_nxt   = '{prio: prio, tag: tag};
              i_nxt     = occ_r[ADDR_W-1:0];
              occ_nxt   = occ_r + CNT_W'(1);
              state_nxt = S_UP_CHK;
            end
          end else if (cmd == CMD_DEQ || cmd == CMD_PEEK) begin
            if (occ_r == '0) begin
              status_nxt = STAT_EMPTY;
              valid_nxt  = 1'b1;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              deq_nxt       = (cmd == CMD_DEQ);
              state_nxt     = S_RD_ROOT;
            end
          end else begin
            valid_nxt = 1'b1;
          end
        end
      end
      S_UP_CHK: begin
        if (i_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = mov_r;
          valid_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = parent;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        if (mov_r.prio > rdata.prio) begin
          mem_req.wdata = rdata;
          i_nxt         = parent;
          state_nxt     = S_UP_CHK;
        end else begin
          mem_req.wdata = mov_r;
          valid_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD_ROOT: begin
        oprio_nxt = rdata.prio;
        otag_nxt  = rdata.tag;
        if (!deq_r || occ_dec == '0) begin
          if (deq_r) begin
            occ_nxt = occ_dec;
          end
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          occ_nxt       = occ_dec;
          n_nxt         = occ_dec[ADDR_W-1:0];
          mem_req.re    = 1'b1;
          mem_req.raddr = occ_dec[ADDR_W-1:0];
          state_nxt     = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        mov_nxt   = rdata;
        i_nxt     = '0;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_c >= n_ext) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = i_r;
          mem_req.wdata = mov_r;
          valid_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = left_c[ADDR_W-1:0];
          state_nxt     = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        if (right_c < n_ext) begin
          child_nxt     = rdata;
          cidx_nxt      = left_c[ADDR_W-1:0];
          mem_req.re    = 1'b1;
          mem_req.raddr = right_c[ADDR_W-1:0];
          state_nxt     = S_DN_RIGHT;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = i_r;
          if (mov_r.prio < rdata.prio) begin
            mem_req.wdata = rdata;
            i_nxt         = left_c[ADDR_W-1:0];
            state_nxt     = S_DN_CHK;
          end else begin
            mem_req.wdata = mov_r;
            valid_nxt     = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_DN_RIGHT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        if (mov_r.prio < big.prio) begin
          mem_req.wdata = big;
          i_nxt         = big_idx;
          state_nxt     = S_DN_CHK;
        end else begin
          mem_req.wdata = mov_r;
          valid_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ocnt_nxt = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      valid_r <= valid_nxt;
    end
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    cidx_r   <= cidx_nxt;
    mov_r    <= mov_nxt;
    child_r  <= child_nxt;
    deq_r    <= deq_nxt;
    status_r <= status_nxt;
    oprio_r  <= oprio_nxt;
    otag_r   <= otag_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_prio   = oprio_r;
  assign res_tag    = otag_r;
  assign res_count  = ocnt_r;

endmodule

// ===== hw/rtl/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue: capacity register,
// heap sequencer and entry RAM. Depends on bhq_pkg, bhq_ctrl and bhq_ram.
//
// Usage:
//   Command channel: drive in_cmd (0 enqueue, 1 dequeue, 2 peek),
//   in_priority_req and in_tag with start high; the transaction is taken at
//   a rising edge where start is high and busy is low. Busy stays high
//   while the heap is being walked.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_priority, out_tag and out_count. The receiver cannot stall, so the
//   result must be taken in that cycle.
//   Sequence: full, empty and unused commands answer straight from idle;
//   peek reads the root; enqueue reads one parent per level climbed, then
//   writes the new entry in place; dequeue reads the root and, unless it
//   takes the last entry, the last entry and the children of each level
//   descended. The next command may start in the cycle of out_valid.
//   Configuration: cfg_capacity is written when cfg_valid and cfg_ready are
//   both high; cfg_ready is high while no command is in flight.
//   Reset (rst_n low, synchronous): empties the queue and sets the capacity
//   to the full heap depth. The entry RAM is not cleared; only written
//   entries are ever read.
module binary_max_heap_queue import bhq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [PRIO_W-1:0] out_priority,
  output logic [TAG_W-1:0]  out_tag,
  output logic [CNT_W-1:0]  out_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_capacity
);

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] limit;
  mem_req_t         mem_req;
  entry_t           rdata;
  logic             ctrl_busy;

  // take capacity writes only while no transaction is in flight
  assign cfg_ready = !ctrl_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  // saturate the capacity to the heap depth; zero makes every enqueue full
  assign limit = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;

  bhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_cmd),
    .prio      (in_priority_req),
    .tag       (in_tag),
    .limit     (limit),
    .busy      (ctrl_busy),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (out_valid),
    .res_status(out_status),
    .res_prio  (out_priority),
    .res_tag   (out_tag),
    .res_count (out_count)
  );

  // entry store: priority and tag side by side in one word
  bhq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(rdata)
  );

  assign busy = ctrl_busy;

endmodule
